[sv/ffha_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg: shared constants, types and helpers for the first-fit allocator
// Heap geometry, field widths, result codes and the stored header format.
// ----------------------------------------------------------------------------
package ffha_pkg;

   // Heap geometry
   parameter int HEAP_BYTES   = 65536;
   parameter int HEADER_BYTES = 8;
   parameter int ALIGN_BYTES  = 8;
   parameter int GUARD_BYTES  = 4;
   parameter int OVERHEAD     = HEADER_BYTES + 2 * GUARD_BYTES;
   parameter int PAYLOAD_SKEW = HEADER_BYTES + GUARD_BYTES;
   parameter int ALIGN_SH     = $clog2(ALIGN_BYTES);

   // Block starts fall on this granule; one header entry per granule
   parameter int SLOT_BYTES = ((ALIGN_BYTES % 8 == 0) && (HEADER_BYTES % 8 == 0)) ? 8 : 4;
   parameter int SLOT_SH    = $clog2(SLOT_BYTES);
   parameter int HDR_DEPTH  = HEAP_BYTES / SLOT_BYTES;
   parameter int IDX_W      = $clog2(HDR_DEPTH);

   // Offsets reach HEAP_BYTES itself; sums of offset and size need headroom
   parameter int OFF_W  = $clog2(HEAP_BYTES) + 1;
   parameter int CALC_W = ((OFF_W > 18) ? OFF_W : 18) + 2;

   // Field widths
   parameter int ADDR_W      = 32;
   parameter int REQ_BYTES_W = 17;
   parameter int LIMIT_W     = 17;
   parameter int SIZE_W      = 17;
   parameter int STATUS_W    = 2;
   parameter int REQ_DATA_W  = 56;
   parameter int RSP_DATA_W  = 40;
   parameter int CSR_IDX_W   = 1;

   // Operation codes
   parameter logic OP_ALLOC = 1'b0;
   parameter logic OP_FREE  = 1'b1;

   // Result status codes
   parameter logic [STATUS_W-1:0] ST_DONE     = 2'd0;
   parameter logic [STATUS_W-1:0] ST_IGNORED  = 2'd1;
   parameter logic [STATUS_W-1:0] ST_NO_SPACE = 2'd2;

   // Configuration register indexes
   parameter logic [CSR_IDX_W-1:0] CSR_HEAP_BASE  = 1'b0;
   parameter logic [CSR_IDX_W-1:0] CSR_HEAP_LIMIT = 1'b1;

   typedef struct packed {
      logic              is_free;
      logic [SIZE_W-1:0] size;
   } hdr_type;

   // Header entry for a heap offset; offsets past the heap land on the last entry
   function automatic logic [IDX_W-1:0] slot_of(input logic [CALC_W-1:0] off);
      logic [CALC_W-1:0] g;
      g = off >> SLOT_SH;
      if (g >= CALC_W'(HDR_DEPTH)) begin
         return IDX_W'(HDR_DEPTH - 1);
      end
      return g[IDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

[sv/ffha_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ffha_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[sv/first_fit_heap_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit allocator over an implicit block list
// Block headers live in one header RAM; a sequencer walks and updates them.
// ----------------------------------------------------------------------------
// One request is worked at a time. The header RAM has one registered read
// port, and the walk visits one block header per cycle. An allocate walks
// the headers, then reuses a free block or appends at the heap top, with a
// second write when it splits a reused block. A free reads the freed
// header, absorbs each free neighbor that follows, and writes the merged
// header when it meets a neighbor in use or the heap top. A zero request,
// null free or free outside the heap goes straight to its result. A finished
// result sits in an output register, and the next request is accepted while
// it waits. The header RAM is not cleared after reset: the walk never reads
// an entry that was not written first, so the block is ready right after reset.
module first_fit_heap_allocator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request: tuser = op
   input  wire logic                                 req_tvalid,
   output      logic                                 req_tready,
   input  wire logic                                 req_tuser,
   // request: tdata = request_bytes[16:0], block_address[48:17], zero pad
   input  wire logic [ffha_pkg::REQ_DATA_W-1:0]      req_tdata,
   // response: tdata = payload_address[31:0], status[33:32], zero pad
   output      logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output      logic [ffha_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // configuration writes
   input  wire logic                                 csr_we,
   input  wire logic [ffha_pkg::CSR_IDX_W-1:0]       csr_addr,
   input  wire logic [ffha_pkg::ADDR_W-1:0]          csr_wdata
);

   localparam int CW = ffha_pkg::CALC_W;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_WALK   = 7'b0000010,
      S_APPEND = 7'b0000100,
      S_SPLIT  = 7'b0001000,
      S_FHEAD  = 7'b0010000,
      S_FMERGE = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type                           state_ff, state_in;
   logic [CW-1:0]                       n_ff, n_in;
   logic [CW-1:0]                       ptr_ff, ptr_in;
   logic [CW-1:0]                       hoff_ff, hoff_in;
   logic [CW-1:0]                       acc_ff, acc_in;
   logic [ffha_pkg::ADDR_W-1:0]         res_addr_ff, res_addr_in;
   logic [ffha_pkg::STATUS_W-1:0]       res_status_ff, res_status_in;
   logic [ffha_pkg::OFF_W-1:0]          heap_top_ff, heap_top_in;
   logic [ffha_pkg::ADDR_W-1:0]         heap_base_ff;
   logic [ffha_pkg::LIMIT_W-1:0]        heap_limit_ff;
   logic                                rsp_tvalid_ff, rsp_tvalid_in;
   logic [ffha_pkg::ADDR_W-1:0]         rsp_addr_ff, rsp_addr_in;
   logic [ffha_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;

   logic                                ram_we;
   logic [ffha_pkg::IDX_W-1:0]          ram_waddr;
   ffha_pkg::hdr_type                   ram_wdata;
   logic [ffha_pkg::IDX_W-1:0]          ram_raddr;
   ffha_pkg::hdr_type                   ram_rdata;

   logic                                req_fire;
   logic [ffha_pkg::REQ_BYTES_W-1:0]    req_bytes;
   logic [ffha_pkg::ADDR_W-1:0]         req_addr;
   logic [CW-1:0]                       lim_c;
   logic [CW-1:0]                       req_n_c;
   logic [ffha_pkg::ADDR_W-1:0]         h_c;
   logic [CW-1:0]                       h_off_c;
   logic [CW-1:0]                       top_c;
   logic [CW-1:0]                       rd_size_c;
   logic [CW-1:0]                       walk_end_c;
   logic [CW-1:0]                       next_c;
   logic [CW-1:0]                       rest_c;
   logic [CW-1:0]                       app_end_c;
   logic [CW-1:0]                       merged_c;
   logic [ffha_pkg::ADDR_W-1:0]         walk_pay_c;
   logic [ffha_pkg::ADDR_W-1:0]         top_pay_c;
   logic                                out_free;

   ffha_ram #(
      .WIDTH ($bits(ffha_pkg::hdr_type)),
      .DEPTH (ffha_pkg::HDR_DEPTH)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_bytes  = req_tdata[ffha_pkg::REQ_BYTES_W-1:0];
   assign req_addr   = req_tdata[ffha_pkg::REQ_BYTES_W +: ffha_pkg::ADDR_W];
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // Datapath terms shared by the states
   assign lim_c      = (CW'(heap_limit_ff) < CW'(ffha_pkg::HEAP_BYTES)) ?
                       CW'(heap_limit_ff) : CW'(ffha_pkg::HEAP_BYTES);
   assign req_n_c    = ((CW'(req_bytes) + CW'(ffha_pkg::ALIGN_BYTES - 1))
                        >> ffha_pkg::ALIGN_SH) << ffha_pkg::ALIGN_SH;
   assign h_c        = req_addr - heap_base_ff - ffha_pkg::ADDR_W'(ffha_pkg::PAYLOAD_SKEW);
   assign h_off_c    = CW'(h_c[ffha_pkg::OFF_W-1:0]);
   assign top_c      = CW'(heap_top_ff);
   assign rd_size_c  = CW'(ram_rdata.size);
   assign walk_end_c = ptr_ff + n_ff + CW'(ffha_pkg::OVERHEAD);
   assign next_c     = ptr_ff + rd_size_c + CW'(ffha_pkg::OVERHEAD);
   assign rest_c     = rd_size_c - n_ff;
   assign app_end_c  = top_c + n_ff + CW'(ffha_pkg::OVERHEAD);
   assign merged_c   = acc_ff + rd_size_c + CW'(ffha_pkg::OVERHEAD);
   assign walk_pay_c = heap_base_ff + ffha_pkg::ADDR_W'(ptr_ff)
                       + ffha_pkg::ADDR_W'(ffha_pkg::PAYLOAD_SKEW);
   assign top_pay_c  = heap_base_ff + ffha_pkg::ADDR_W'(heap_top_ff)
                       + ffha_pkg::ADDR_W'(ffha_pkg::PAYLOAD_SKEW);

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      ptr_in        = ptr_ff;
      hoff_in       = hoff_ff;
      acc_in        = acc_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      heap_top_in   = heap_top_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = ffha_pkg::slot_of(ptr_ff);
      ram_wdata     = '{is_free: 1'b0, size: ffha_pkg::SIZE_W'(n_ff)};
      ram_raddr     = ffha_pkg::slot_of(ptr_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_addr_in   = '0;
               res_status_in = ffha_pkg::ST_DONE;
               n_in          = req_n_c;
               if (req_tuser == ffha_pkg::OP_ALLOC) begin
                  if (req_bytes == '0) begin
                     res_status_in = ffha_pkg::ST_IGNORED;
                     state_in      = S_DONE;
                  end else if (heap_top_ff == '0) begin
                     state_in = S_APPEND;
                  end else begin
                     ptr_in    = '0;
                     ram_raddr = ffha_pkg::slot_of('0);
                     state_in  = S_WALK;
                  end
               end else begin
                  if ((req_addr == '0) ||
                      (h_c >= ffha_pkg::ADDR_W'(heap_top_ff))) begin
                     res_status_in = ffha_pkg::ST_IGNORED;
                     state_in      = S_DONE;
                  end else begin
                     ptr_in    = h_off_c;
                     hoff_in   = h_off_c;
                     ram_raddr = ffha_pkg::slot_of(h_off_c);
                     state_in  = S_FHEAD;
                  end
               end
            end
         end
         S_WALK: begin
            if (walk_end_c > lim_c) begin
               res_status_in = ffha_pkg::ST_NO_SPACE;
               state_in      = S_DONE;
            end else if (ram_rdata.is_free && (rd_size_c >= n_ff)) begin
               ram_we      = 1'b1;
               res_addr_in = walk_pay_c;
               if (rest_c >= CW'(ffha_pkg::OVERHEAD)) begin
                  // split: tail becomes a new free block
                  hoff_in  = walk_end_c;
                  acc_in   = rest_c - CW'(ffha_pkg::OVERHEAD);
                  state_in = S_SPLIT;
               end else begin
                  ram_wdata = '{is_free: 1'b0, size: ram_rdata.size};
                  state_in  = S_DONE;
               end
            end else begin
               ptr_in = next_c;
               if (next_c < top_c) begin
                  ram_raddr = ffha_pkg::slot_of(next_c);
               end else begin
                  state_in = S_APPEND;
               end
            end
         end
         S_APPEND: begin
            if (app_end_c > lim_c) begin
               res_status_in = ffha_pkg::ST_NO_SPACE;
            end else begin
               ram_we      = 1'b1;
               ram_waddr   = ffha_pkg::slot_of(top_c);
               res_addr_in = top_pay_c;
               heap_top_in = app_end_c[ffha_pkg::OFF_W-1:0];
            end
            state_in = S_DONE;
         end
         S_SPLIT: begin
            ram_we    = 1'b1;
            ram_waddr = ffha_pkg::slot_of(hoff_ff);
            ram_wdata = '{is_free: 1'b1, size: ffha_pkg::SIZE_W'(acc_ff)};
            state_in  = S_DONE;
         end
         S_FHEAD: begin
            acc_in = rd_size_c;
            if (next_c >= top_c) begin
               ram_we    = 1'b1;
               ram_waddr = ffha_pkg::slot_of(hoff_ff);
               ram_wdata = '{is_free: 1'b1, size: ram_rdata.size};
               state_in  = S_DONE;
            end else begin
               ptr_in    = next_c;
               ram_raddr = ffha_pkg::slot_of(next_c);
               state_in  = S_FMERGE;
            end
         end
         S_FMERGE: begin
            if (!ram_rdata.is_free) begin
               ram_we    = 1'b1;
               ram_waddr = ffha_pkg::slot_of(hoff_ff);
               ram_wdata = '{is_free: 1'b1, size: ffha_pkg::SIZE_W'(acc_ff)};
               state_in  = S_DONE;
            end else begin
               // absorb the free neighbor, then look past it
               acc_in = merged_c;
               ptr_in = next_c;
               if (next_c >= top_c) begin
                  ram_we    = 1'b1;
                  ram_waddr = ffha_pkg::slot_of(hoff_ff);
                  ram_wdata = '{is_free: 1'b1, size: ffha_pkg::SIZE_W'(merged_c)};
                  state_in  = S_DONE;
               end else begin
                  ram_raddr = ffha_pkg::slot_of(next_c);
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         heap_top_ff   <= '0;
         heap_base_ff  <= '0;
         heap_limit_ff <= ffha_pkg::LIMIT_W'(ffha_pkg::HEAP_BYTES);
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         heap_top_ff   <= heap_top_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_we) begin
            if (csr_addr == ffha_pkg::CSR_HEAP_BASE) begin
               heap_base_ff <= csr_wdata;
            end else begin
               heap_limit_ff <= csr_wdata[ffha_pkg::LIMIT_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      ptr_ff        <= ptr_in;
      hoff_ff       <= hoff_in;
      acc_ff        <= acc_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(ffha_pkg::RSP_DATA_W - ffha_pkg::ADDR_W - ffha_pkg::STATUS_W){1'b0}},
                        rsp_status_ff, rsp_addr_ff};

endmodule
`default_nettype wire

[sv/ffha_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_checker: port-level checks for the first-fit allocator
// Watches the request and response beats and the result codes over time.
// ----------------------------------------------------------------------------
module ffha_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             req_tuser,
   input wire logic [ffha_pkg::REQ_DATA_W-1:0]  req_tdata,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [ffha_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic                             csr_we,
   input wire logic [ffha_pkg::CSR_IDX_W-1:0]   csr_addr,
   input wire logic [ffha_pkg::ADDR_W-1:0]      csr_wdata
);

   logic [1:0]                    pending_ff, pending_in;
   logic                          in_beat;
   logic                          out_beat;
   logic [ffha_pkg::STATUS_W-1:0] status;
   logic [ffha_pkg::ADDR_W-1:0]   pay_addr;
   logic                          unused_ok;

   assign in_beat   = req_tvalid && req_tready;
   assign out_beat  = rsp_tvalid && rsp_tready;
   assign status    = rsp_tdata[ffha_pkg::ADDR_W +: ffha_pkg::STATUS_W];
   assign pay_addr  = rsp_tdata[ffha_pkg::ADDR_W-1:0];
   assign unused_ok = ^{req_tuser, req_tdata, csr_we, csr_addr, csr_wdata};

   // Count requests taken but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (in_beat && !out_beat) begin
         pending_in = pending_ff + 2'd1;
      end else if (!in_beat && out_beat) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response beat changed or dropped");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((status == ffha_pkg::ST_DONE) || (status == ffha_pkg::ST_IGNORED) ||
                      (status == ffha_pkg::ST_NO_SPACE)))
      else $error("response carries an undefined status");

   a_fail_null: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (status != ffha_pkg::ST_DONE)) |-> (pay_addr == '0))
      else $error("failed or ignored request returned an address");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset || unused_ok === 1'bx)
      rsp_tvalid |-> (pending_ff != 2'd0))
      else $error("response beat without an outstanding request");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);
`default_nettype wire

[verif/tb_first_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator: self-checking bench for the first-fit allocator
// A shadow copy of the block headers predicts each response. Directed beats
// cover the special cases, then random allocate/free traffic runs in phases
// with different heap base, heap limit and handshake pressure.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;

   localparam int GRANULES = ffha_pkg::HEAP_BYTES / 4;

   typedef struct packed {
      logic [ffha_pkg::ADDR_W-1:0]   payload;
      logic [ffha_pkg::STATUS_W-1:0] status;
   } alloc_rsp_type;

   // Shadow of the header store, heap top and registers
   class heap_shadow;
      bit [ffha_pkg::ADDR_W-1:0]  base;
      bit [ffha_pkg::LIMIT_W-1:0] limit;
      int unsigned                top;
      bit [ffha_pkg::SIZE_W-1:0]  size_at [GRANULES];
      bit                         free_at [GRANULES];
      bit                         written_at [GRANULES];
      alloc_rsp_type              awaited_results [$];
      int                         errors;

      function new();
         base   = '0;
         limit  = ffha_pkg::LIMIT_W'(ffha_pkg::HEAP_BYTES);
         top    = 0;
         errors = 0;
      endfunction

      function int unsigned granule(input int unsigned off);
         return ((off >> 2) < GRANULES) ? (off >> 2) : (GRANULES - 1);
      endfunction

      function void put_header(input int unsigned off, input int unsigned sz, input bit f);
         int unsigned i;
         i = granule(off);
         size_at[i]    = sz[ffha_pkg::SIZE_W-1:0];
         free_at[i]    = f;
         written_at[i] = 1'b1;
      endfunction

      function void set_reg(input logic [ffha_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ffha_pkg::ADDR_W-1:0] value);
         if (idx == ffha_pkg::CSR_HEAP_BASE) begin
            base = value;
         end else begin
            limit = value[ffha_pkg::LIMIT_W-1:0];
         end
      endfunction

      // A free may only hit a block start that was written once, be null, or land at or past the top
      function bit may_free(input bit [ffha_pkg::ADDR_W-1:0] addr);
         bit [ffha_pkg::ADDR_W-1:0] h;
         h = addr - base - ffha_pkg::PAYLOAD_SKEW;
         if (addr == 0 || h >= top) begin
            return 1'b1;
         end
         return (h[2:0] == 3'd0) && written_at[h >> 2];
      endfunction

      function alloc_rsp_type note_request(input logic op,
                                           input bit [ffha_pkg::REQ_BYTES_W-1:0] bytes,
                                           input bit [ffha_pkg::ADDR_W-1:0] addr);
         alloc_rsp_type             r;
         int unsigned               lim, n, t, s, rest, nx;
         bit [ffha_pkg::ADDR_W-1:0] h;
         bit                        done;
         r.payload = '0;
         r.status  = ffha_pkg::ST_DONE;
         done      = 1'b0;
         if (op == ffha_pkg::OP_ALLOC) begin
            lim = (32'(limit) < ffha_pkg::HEAP_BYTES) ? 32'(limit) : ffha_pkg::HEAP_BYTES;
            if (bytes == 0) begin
               r.status = ffha_pkg::ST_IGNORED;
            end else begin
               n = (32'(bytes) + ffha_pkg::ALIGN_BYTES - 1) / ffha_pkg::ALIGN_BYTES
                   * ffha_pkg::ALIGN_BYTES;
               t = 0;
               while (!done && t < top) begin
                  s = 32'(size_at[granule(t)]);
                  if (t + n + ffha_pkg::OVERHEAD > lim) begin
                     r.status = ffha_pkg::ST_NO_SPACE;
                     done     = 1'b1;
                  end else if (free_at[granule(t)] && s >= n) begin
                     rest = s - n;
                     // split only when the spare part holds a whole block
                     if (rest >= ffha_pkg::OVERHEAD) begin
                        put_header(t, n, 1'b0);
                        put_header(t + ffha_pkg::OVERHEAD + n, rest - ffha_pkg::OVERHEAD, 1'b1);
                     end else begin
                        put_header(t, s, 1'b0);
                     end
                     r.payload = base + t + ffha_pkg::PAYLOAD_SKEW;
                     done      = 1'b1;
                  end else begin
                     t += s + ffha_pkg::OVERHEAD;
                  end
               end
               if (!done) begin
                  if (top + n + ffha_pkg::OVERHEAD > lim) begin
                     r.status = ffha_pkg::ST_NO_SPACE;
                  end else begin
                     put_header(top, n, 1'b0);
                     r.payload = base + top + ffha_pkg::PAYLOAD_SKEW;
                     top += n + ffha_pkg::OVERHEAD;
                  end
               end
            end
         end else if (addr == 0) begin
            r.status = ffha_pkg::ST_IGNORED;
         end else begin
            h = addr - base - ffha_pkg::PAYLOAD_SKEW;
            if (h >= top) begin
               r.status = ffha_pkg::ST_IGNORED;
            end else begin
               s = 32'(size_at[granule(h)]);
               // absorb every free block that directly follows
               while (!done) begin
                  nx = h + s + ffha_pkg::OVERHEAD;
                  if (nx >= top || !free_at[granule(nx)]) begin
                     done = 1'b1;
                  end else begin
                     s += 32'(size_at[granule(nx)]) + ffha_pkg::OVERHEAD;
                  end
               end
               put_header(h, s, 1'b1);
            end
         end
         awaited_results.push_back(r);
         return r;
      endfunction

      function void check_response(input logic [ffha_pkg::RSP_DATA_W-1:0] data);
         alloc_rsp_type e;
         if (awaited_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %h", $time, data);
            return;
         end
         e = awaited_results.pop_front();
         if (data[ffha_pkg::ADDR_W-1:0] !== e.payload) begin
            errors++;
            $display("%0t: payload_address mismatch, expected %h, actual %h",
                     $time, e.payload, data[ffha_pkg::ADDR_W-1:0]);
         end
         if (data[ffha_pkg::ADDR_W +: ffha_pkg::STATUS_W] !== e.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, e.status, data[ffha_pkg::ADDR_W +: ffha_pkg::STATUS_W]);
         end
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic                              req_tuser = 1'b0;
   logic [ffha_pkg::REQ_DATA_W-1:0]   req_tdata = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [ffha_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                              csr_we = 1'b0;
   logic [ffha_pkg::CSR_IDX_W-1:0]    csr_addr = '0;
   logic [ffha_pkg::ADDR_W-1:0]       csr_wdata = '0;

   heap_shadow  shadow;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int unsigned live_offs [$];
   int unsigned freed_offs [$];

   first_fit_heap_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #300_000_000;
      $display("Verification failed");
      $finish;
   end

   always @(negedge clock) begin
      rsp_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         shadow.check_response(rsp_tdata);
      end
   end

   function automatic logic [ffha_pkg::REQ_BYTES_W-1:0] rand_bytes(input int unsigned hi,
                                                                   input int unsigned lo);
      return ffha_pkg::REQ_BYTES_W'($urandom_range(hi, lo));
   endfunction

   // Present one beat and hold it until accepted; returns at the next falling edge
   task automatic push_request(input logic op, input logic [ffha_pkg::REQ_BYTES_W-1:0] bytes,
                               input logic [ffha_pkg::ADDR_W-1:0] addr,
                               output alloc_rsp_type r);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= ffha_pkg::REQ_DATA_W'({addr, bytes});
      do @(posedge clock); while (req_tready !== 1'b1);
      r = shadow.note_request(op, bytes, addr);
      @(negedge clock);
   endtask

   task automatic alloc_bytes(input logic [ffha_pkg::REQ_BYTES_W-1:0] bytes);
      alloc_rsp_type r;
      push_request(ffha_pkg::OP_ALLOC, bytes, $urandom, r);
      if (r.status == ffha_pkg::ST_DONE) begin
         live_offs.push_back(r.payload - shadow.base - ffha_pkg::PAYLOAD_SKEW);
      end
   endtask

   task automatic release_live(input int unsigned idx);
      alloc_rsp_type r;
      int unsigned   off;
      off = live_offs[idx];
      live_offs.delete(idx);
      push_request(ffha_pkg::OP_FREE, rand_bytes(ffha_pkg::HEAP_BYTES, 0),
                   shadow.base + off + ffha_pkg::PAYLOAD_SKEW, r);
      freed_offs.push_back(off);
      if (freed_offs.size() > 64) begin
         void'(freed_offs.pop_front());
      end
   endtask

   // Drop valid and wait out every awaited response
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (shadow.awaited_results.size() != 0);
      repeat (16) @(negedge clock);
   endtask

   task automatic write_csr(input logic [ffha_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ffha_pkg::ADDR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      shadow.set_reg(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_items(input int count);
      alloc_rsp_type               r;
      int unsigned                 sel;
      logic [ffha_pkg::ADDR_W-1:0] a;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(199) == 0) begin
            settle();
         end
         if ($urandom_range(99) < ((live_offs.size() > 48) ? 35 : 58)) begin
            sel = $urandom_range(99);
            if (sel < 2) begin
               alloc_bytes('0);
            end else if (sel < 42) begin
               alloc_bytes(rand_bytes(64, 1));
            end else if (sel < 87) begin
               alloc_bytes(rand_bytes(1024, 65));
            end else if (sel < 97) begin
               alloc_bytes(rand_bytes(8192, 1025));
            end else begin
               alloc_bytes(rand_bytes(ffha_pkg::HEAP_BYTES, 8193));
            end
         end else begin
            sel = $urandom_range(99);
            if (sel < 75 && live_offs.size() > 0) begin
               release_live($urandom_range(live_offs.size() - 1));
            end else if (sel < 83) begin
               push_request(ffha_pkg::OP_FREE, rand_bytes(ffha_pkg::HEAP_BYTES, 0), '0, r);
            end else if (sel < 91 && freed_offs.size() > 0) begin
               // free again a block start freed earlier
               a = shadow.base + freed_offs[$urandom_range(freed_offs.size() - 1)]
                   + ffha_pkg::PAYLOAD_SKEW;
               push_request(ffha_pkg::OP_FREE, rand_bytes(ffha_pkg::HEAP_BYTES, 0), a, r);
            end else begin
               do a = $urandom; while (!shadow.may_free(a));
               push_request(ffha_pkg::OP_FREE, rand_bytes(ffha_pkg::HEAP_BYTES, 0), a, r);
            end
         end
      end
   endtask

   initial begin
      alloc_rsp_type r;
      shadow = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_request(ffha_pkg::OP_ALLOC, '0, 32'hFFFF_FFFF, r);      // zero request
      push_request(ffha_pkg::OP_FREE, 17'h10000, '0, r);           // null free
      push_request(ffha_pkg::OP_FREE, '0, 32'hFFFF_FFFF, r);       // far outside the heap
      alloc_bytes(17'd100);
      alloc_bytes(17'd8);
      alloc_bytes(17'd40);
      alloc_bytes(17'd1);
      // at the top
      push_request(ffha_pkg::OP_FREE, '0,
                   shadow.base + shadow.top + ffha_pkg::PAYLOAD_SKEW, r);
      release_live(1);
      release_live(0);                                             // merge with the next block
      alloc_bytes(17'd64);                                         // reuse and split
      alloc_bytes(17'd48);                                         // exact fit
      release_live(0);
      alloc_bytes(17'd32);                                         // remainder too small to split
      alloc_bytes(17'h10000);                                      // out of space
      // fill up to the limit
      alloc_bytes(ffha_pkg::REQ_BYTES_W'(ffha_pkg::HEAP_BYTES - shadow.top
                                          - ffha_pkg::OVERHEAD));
      alloc_bytes(17'd8);
      release_live(live_offs.size() - 1);
      alloc_bytes(ffha_pkg::REQ_BYTES_W'(ffha_pkg::HEAP_BYTES - 224 - ffha_pkg::OVERHEAD + 8));
      alloc_bytes(17'd1);
      // double free
      push_request(ffha_pkg::OP_FREE, '0,
                   shadow.base + freed_offs[0] + ffha_pkg::PAYLOAD_SKEW, r);
      while (live_offs.size() > 0) begin
         release_live(0);
      end
      random_items(230);
      settle();

      write_csr(ffha_pkg::CSR_HEAP_BASE, 32'h8000_0000);
      write_csr(ffha_pkg::CSR_HEAP_LIMIT, 32'hFFFF_FFFF);
      idle_pct  = 67;
      stall_pct = 0;
      random_items(250);
      settle();

      // base chosen so that offset zero maps to address zero
      write_csr(ffha_pkg::CSR_HEAP_BASE, 32'hFFFF_FFF4);
      write_csr(ffha_pkg::CSR_HEAP_LIMIT, 32'd4096);
      idle_pct  = 0;
      stall_pct = 67;
      random_items(200);
      settle();

      write_csr(ffha_pkg::CSR_HEAP_BASE, $urandom);
      write_csr(ffha_pkg::CSR_HEAP_LIMIT, '0);
      idle_pct  = 26;
      stall_pct = 26;
      random_items(60);
      settle();

      write_csr(ffha_pkg::CSR_HEAP_BASE, 32'hFFFF_FFFF);
      write_csr(ffha_pkg::CSR_HEAP_LIMIT, 32'(ffha_pkg::HEAP_BYTES));
      random_items(220);
      settle();

      write_csr(ffha_pkg::CSR_HEAP_BASE, $urandom);
      write_csr(ffha_pkg::CSR_HEAP_LIMIT, shadow.top + 200);
      idle_pct  = 0;
      stall_pct = 0;
      random_items(150);
      settle();

      if (shadow.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[files.f]
sv/ffha_pkg.sv
sv/ffha_ram.sv
sv/first_fit_heap_allocator.sv
sv/ffha_checker.sv
verif/tb_first_fit_heap_allocator.sv
